// ===== sv/mhpq_pkg.sv =====
package mhpq_pkg;

  localparam int DATA_W     = 32;
  localparam int TOTAL_W    = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic                     operation;
    logic signed [DATA_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    logic signed [DATA_W-1:0] top_value;
    logic                     is_empty;
    logic [TOTAL_W-1:0]       entry_total;
    logic [1:0]               status;
  } rsp_t;

  typedef enum logic [1:0] {
    KIND_PUSH,
    KIND_PUSH_FULL,
    KIND_POP,
    KIND_POP_EMPTY
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_LAST,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_DONE
  } state_t;

endpackage

// ===== sv/mhpq_stream_if.sv =====
interface mhpq_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/mhpq_front.sv =====
module mhpq_front #(
  parameter int HEAP_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  mhpq_stream_if.sink   cmd,
  mhpq_stream_if.source q
);

  localparam int CW = $clog2(HEAP_DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          full;
  logic          empty;
  mhpq_pkg::kind_t kind;

  assign full  = (count == CW'(HEAP_DEPTH));
  assign empty = (count == '0);

  // classify against the count as it stands once all queued work is done
  always_comb begin
    count_next = count;
    if (cmd.payload.operation == mhpq_pkg::OP_PUSH) begin
      kind = full ? mhpq_pkg::KIND_PUSH_FULL : mhpq_pkg::KIND_PUSH;
      if (!full) count_next = count + 1'b1;
    end else begin
      kind = empty ? mhpq_pkg::KIND_POP_EMPTY : mhpq_pkg::KIND_POP;
      if (!empty) count_next = count - 1'b1;
    end
  end

  assign q.valid         = cmd.valid;
  assign q.payload.kind  = kind;
  assign q.payload.value = cmd.payload.value;
  assign cmd.ready       = q.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.valid && cmd.ready) begin
      count <= count_next;
    end
  end

endmodule

// ===== sv/mhpq_cmd_fifo.sv =====
module mhpq_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  mhpq_stream_if.sink   wr,
  mhpq_stream_if.source rd
);

  mhpq_pkg::cmd_t                  slots [mhpq_pkg::QUEUE_DEPTH];
  logic [mhpq_pkg::QPTR_W-1:0]     wr_ptr;
  logic [mhpq_pkg::QPTR_W-1:0]     rd_ptr;
  logic [mhpq_pkg::QCNT_W-1:0]     fill;
  logic                            do_wr;
  logic                            do_rd;

  assign wr.ready   = (fill != mhpq_pkg::QCNT_W'(mhpq_pkg::QUEUE_DEPTH));
  assign rd.valid   = (fill != '0);
  assign rd.payload = slots[rd_ptr];
  assign do_wr      = wr.valid && wr.ready;
  assign do_rd      = rd.valid && rd.ready;

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr.payload;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == mhpq_pkg::QPTR_W'(mhpq_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == mhpq_pkg::QPTR_W'(mhpq_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) fill <= fill + 1'b1;
      else if (do_rd && !do_wr) fill <= fill - 1'b1;
    end
  end

endmodule

// ===== sv/mhpq_back.sv =====
module mhpq_back #(
  parameter int HEAP_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  mhpq_stream_if.sink   q,
  mhpq_stream_if.source res
);

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int CH = AW + 2;

  mhpq_pkg::state_t state;
  mhpq_pkg::state_t state_next;

  logic signed [mhpq_pkg::DATA_W-1:0] mem [HEAP_DEPTH];
  logic signed [mhpq_pkg::DATA_W-1:0] rd0;
  logic signed [mhpq_pkg::DATA_W-1:0] rd1;
  logic signed [mhpq_pkg::DATA_W-1:0] root;
  logic [AW-1:0]                      ra0;
  logic [AW-1:0]                      ra1;
  logic                               we;
  logic [AW-1:0]                      wa;
  logic signed [mhpq_pkg::DATA_W-1:0] wd;

  logic [CW-1:0]                      n;
  logic [CW-1:0]                      n_next;
  logic [AW-1:0]                      pos;
  logic [AW-1:0]                      pos_next;
  logic signed [mhpq_pkg::DATA_W-1:0] x;
  logic signed [mhpq_pkg::DATA_W-1:0] x_next;
  logic signed [mhpq_pkg::DATA_W-1:0] removed;
  logic signed [mhpq_pkg::DATA_W-1:0] removed_next;
  logic [1:0]                         status;
  logic [1:0]                         status_next;
  mhpq_pkg::rsp_t                     out_r;
  logic                               out_valid;
  logic                               load_out;

  logic [AW-1:0]                      parent;
  logic [CH-1:0]                      child_l;
  logic [CH-1:0]                      child_r;
  logic                               has_l;
  logic                               has_r;
  logic                               pick_r;
  logic signed [mhpq_pkg::DATA_W-1:0] big;

  assign parent  = AW'((pos - 1'b1) >> 1);
  assign child_l = CH'({pos, 1'b1});
  assign child_r = child_l + 1'b1;
  assign has_l   = child_l < CH'(n);
  assign has_r   = child_r < CH'(n);
  assign pick_r  = has_r && (rd1 > rd0);
  assign big     = pick_r ? rd1 : rd0;

  assign q.ready   = (state == mhpq_pkg::ST_IDLE);
  assign res.valid = out_valid;
  assign res.payload = out_r;

  always_comb begin
    state_next   = state;
    n_next       = n;
    pos_next     = pos;
    x_next       = x;
    removed_next = removed;
    status_next  = status;
    ra0          = AW'(n - 1'b1);
    ra1          = AW'(child_r);
    we           = 1'b0;
    wa           = pos;
    wd           = x;
    load_out     = 1'b0;
    unique case (state)
      mhpq_pkg::ST_IDLE: begin
        ra0 = AW'(n - 1'b1);
        if (q.valid) begin
          removed_next = '0;
          status_next  = mhpq_pkg::STATUS_OK;
          unique case (q.payload.kind)
            mhpq_pkg::KIND_PUSH: begin
              pos_next   = AW'(n);
              x_next     = q.payload.value;
              n_next     = n + 1'b1;
              state_next = mhpq_pkg::ST_UP_RD;
            end
            mhpq_pkg::KIND_POP: begin
              // last entry is being read this cycle
              removed_next = root;
              n_next       = n - 1'b1;
              state_next   = mhpq_pkg::ST_POP_LAST;
            end
            mhpq_pkg::KIND_PUSH_FULL: begin
              status_next = mhpq_pkg::STATUS_FULL;
              state_next  = mhpq_pkg::ST_DONE;
            end
            mhpq_pkg::KIND_POP_EMPTY: begin
              status_next = mhpq_pkg::STATUS_EMPTY;
              state_next  = mhpq_pkg::ST_DONE;
            end
            default: state_next = mhpq_pkg::ST_IDLE;
          endcase
        end
      end
      mhpq_pkg::ST_POP_LAST: begin
        x_next   = rd0;
        pos_next = '0;
        state_next = (n == '0) ? mhpq_pkg::ST_DONE : mhpq_pkg::ST_DN_RD;
      end
      mhpq_pkg::ST_UP_RD: begin
        ra0 = parent;
        if (pos == '0) begin
          we         = 1'b1;
          state_next = mhpq_pkg::ST_DONE;
        end else begin
          state_next = mhpq_pkg::ST_UP_CMP;
        end
      end
      mhpq_pkg::ST_UP_CMP: begin
        we = 1'b1;
        if (x > rd0) begin
          // parent moves down, hole moves up
          wd         = rd0;
          pos_next   = parent;
          state_next = mhpq_pkg::ST_UP_RD;
        end else begin
          state_next = mhpq_pkg::ST_DONE;
        end
      end
      mhpq_pkg::ST_DN_RD: begin
        ra0 = AW'(child_l);
        ra1 = AW'(child_r);
        if (!has_l) begin
          we         = 1'b1;
          state_next = mhpq_pkg::ST_DONE;
        end else begin
          state_next = mhpq_pkg::ST_DN_CMP;
        end
      end
      mhpq_pkg::ST_DN_CMP: begin
        we = 1'b1;
        if (big > x) begin
          wd         = big;
          pos_next   = pick_r ? AW'(child_r) : AW'(child_l);
          state_next = mhpq_pkg::ST_DN_RD;
        end else begin
          state_next = mhpq_pkg::ST_DONE;
        end
      end
      mhpq_pkg::ST_DONE: begin
        if (!out_valid || res.ready) begin
          load_out   = 1'b1;
          state_next = mhpq_pkg::ST_IDLE;
        end
      end
      default: state_next = mhpq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhpq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      n <= n_next;
      if (load_out) out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pos     <= pos_next;
    x       <= x_next;
    removed <= removed_next;
    status  <= status_next;
    if (load_out) begin
      out_r.removed_value <= removed;
      out_r.top_value     <= (n != '0) ? root : '0;
      out_r.is_empty      <= (n == '0);
      out_r.entry_total   <= mhpq_pkg::TOTAL_W'(n);
      out_r.status        <= status;
    end
  end

  // heap store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

  // copy of entry zero for the top of heap
  always_ff @(posedge clk) begin
    if (we && (wa == '0)) root <= wd;
  end

endmodule

// ===== sv/max_heap_priority_queue.sv =====
// channel | dir | payload                                        | transaction
// cmd     | in  | operation, value                               | valid && ready
// res     | out | removed_value, top_value, is_empty,            | valid && ready
//         |     | entry_total, status                            |
//
// push writes the new entry at the end and lets it climb one level at a time;
// pop moves the last entry to the root and lets it sink; dropped ops skip the heap.
// each level costs one registered read of the heap store and one compare/write.
// a two-entry command queue keeps cmd open while the heap engine works, until it fills.
// rst is synchronous; the heap store is not cleared, only counts, pointers and state are.
// a stalled res holds its result; the engine waits until the slot frees.
module max_heap_priority_queue #(
  parameter int HEAP_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  mhpq_stream_if.sink   cmd,
  mhpq_stream_if.source res
);

  mhpq_stream_if #(.payload_t(mhpq_pkg::cmd_t)) front_q ();
  mhpq_stream_if #(.payload_t(mhpq_pkg::cmd_t)) back_q ();

  mhpq_front #(.HEAP_DEPTH(HEAP_DEPTH)) u_front (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .q   (front_q)
  );

  mhpq_cmd_fifo u_fifo (
    .clk (clk),
    .rst (rst),
    .wr  (front_q),
    .rd  (back_q)
  );

  mhpq_back #(.HEAP_DEPTH(HEAP_DEPTH)) u_back (
    .clk (clk),
    .rst (rst),
    .q   (back_q),
    .res (res)
  );

endmodule

// ===== sv/mhpq_checker.sv =====
module mhpq_checker #(
  parameter int HEAP_DEPTH = 64
) (
  input logic           clk,
  input logic           rst,
  input logic           res_valid,
  input logic           res_ready,
  input mhpq_pkg::rsp_t res_payload
);

  // a stalled result stays put
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_payload))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_payload.is_empty == (res_payload.entry_total == '0)))
    else $error("empty flag disagrees with entry total");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_payload.status == mhpq_pkg::STATUS_FULL |->
      res_payload.entry_total == mhpq_pkg::TOTAL_W'(HEAP_DEPTH) &&
      res_payload.removed_value == '0)
    else $error("full push result inconsistent");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_payload.status == mhpq_pkg::STATUS_EMPTY |->
      res_payload.is_empty && res_payload.removed_value == '0 &&
      res_payload.top_value == '0)
    else $error("empty pop result inconsistent");

  assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result offered right after reset");

endmodule

bind max_heap_priority_queue mhpq_checker #(.HEAP_DEPTH(HEAP_DEPTH)) u_chk (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_payload (res.payload)
);
